[hdl/fpam_pkg.sv]
// Package of types, codes and address constants for the flash protection access monitor.
`default_nettype none

package fpam_pkg;

  // Number of 4 KiB RAM pages covered by the execute forbid mask.
  localparam int unsigned RamPages = 64;

  typedef enum logic [1:0] {
    OpRead  = 2'd0,
    OpWrite = 2'd1,
    OpFetch = 2'd2
  } fpam_op_e;

  typedef enum logic [1:0] {
    ViolNone    = 2'd0,
    ViolArchive = 2'd1,
    ViolRamExec = 2'd2
  } fpam_viol_e;

  typedef enum logic [1:0] {
    RegHwGen    = 2'd0,
    RegRomPage  = 2'd1,
    RegExecMask = 2'd2,
    RegHighExec = 2'd3
  } fpam_reg_e;

  // Absolute address windows.
  localparam logic [23:0] ArchiveLo  = 24'h040000;
  localparam logic [23:0] ArchiveHi  = 24'h0fffff;
  localparam logic [23:0] ScreenLo   = 24'h180000;
  localparam logic [23:0] ScreenHi   = 24'h1bffff;
  localparam logic [23:0] ToggleLo   = 24'h1c0000;
  localparam logic [23:0] ToggleHi   = 24'h1fffff;
  localparam logic [23:0] LowRamHi   = 24'h03ffff;
  localparam logic [23:0] HighRamHi  = 24'h1fffff;

  // Windows relative to the flash base (absolute address minus rom_page * 0x10000).
  localparam logic [23:0] FlBootLo   = 24'h000000;
  localparam logic [23:0] FlBootHi   = 24'h00ffff;
  localparam logic [23:0] FlCertLo   = 24'h010000;
  localparam logic [23:0] FlCertHi   = 24'h011fff;
  localparam logic [23:0] FlAuthALo  = 24'h012000;
  localparam logic [23:0] FlAuthAHi  = 24'h017fff;
  localparam logic [23:0] FlProtLo   = 24'h018000;
  localparam logic [23:0] FlProtHi   = 24'h019fff;
  localparam logic [23:0] FlAuthBLo  = 24'h01a000;
  localparam logic [23:0] FlAuthBHi  = 24'h01ffff;
  localparam logic [23:0] FlFetchLo  = 24'h190000;
  localparam logic [23:0] FlFetchHi  = 24'h1fffff;

  localparam logic [7:0] AuthFireCount  = 8'd3;
  localparam logic [7:0] AuthSecondFire = 8'd8;
  localparam logic [7:0] CrashCount     = 8'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] address;
    logic [7:0]  write_data;
  } fpam_item_t;

  typedef struct packed {
    logic        memory_enable;
    logic        read_override;
    logic [7:0]  write_data_out;
    logic [1:0]  violation;
    logic        halt_cpu;
    logic        protect_state;
    logic [2:0]  archive_limit_now;
  } fpam_result_t;

  typedef struct packed {
    logic        hw_generation;
    logic [6:0]  rom_page;
    logic [63:0] ram_exec_forbid_mask;
    logic        high_ram_exec_forbid;
  } fpam_cfg_t;

  typedef struct packed {
    logic        protect_flag;
    logic [2:0]  archive_limit_bits;
    logic [7:0]  auth_count_first;
    logic [7:0]  auth_count_second;
    logic [7:0]  toggle_crash_count;
    logic [7:0]  archive_crash_count;
  } fpam_state_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hff) ? v : v + 8'd1;
  endfunction

endpackage

`default_nettype wire

[hdl/fpam_if.sv]
// Handshake interfaces for the access, result and configuration channels.
`default_nettype none

interface fpam_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [23:0] address;
  logic [7:0]  write_data;

  modport source (output valid, output op, output address, output write_data, input ready);
  modport sink (input valid, input op, input address, input write_data, output ready);
endinterface

interface fpam_result_if;
  logic        valid;
  logic        ready;
  logic        memory_enable;
  logic        read_override;
  logic [7:0]  write_data_out;
  logic [1:0]  violation;
  logic        halt_cpu;
  logic        protect_state;
  logic [2:0]  archive_limit_now;

  modport source (
    output valid, output memory_enable, output read_override, output write_data_out,
    output violation, output halt_cpu, output protect_state, output archive_limit_now,
    input ready
  );
  modport sink (
    input valid, input memory_enable, input read_override, input write_data_out,
    input violation, input halt_cpu, input protect_state, input archive_limit_now,
    output ready
  );
endinterface

interface fpam_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/fpam_cfg.sv]
// Configuration register file of the flash protection access monitor.
`default_nettype none

module fpam_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  fpam_cfg_if.sink           cfg_i,
  output fpam_pkg::fpam_cfg_t cfg_o
);

  fpam_pkg::fpam_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (fpam_pkg::fpam_reg_e'(cfg_i.index))
        fpam_pkg::RegHwGen:    cfg_d.hw_generation        = cfg_i.data[0];
        fpam_pkg::RegRomPage:  cfg_d.rom_page             = cfg_i.data[6:0];
        fpam_pkg::RegExecMask: cfg_d.ram_exec_forbid_mask = cfg_i.data;
        fpam_pkg::RegHighExec: cfg_d.high_ram_exec_forbid = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hw_generation        <= 1'b0;
      cfg_q.rom_page             <= 7'd32;
      cfg_q.ram_exec_forbid_mask <= '0;
      cfg_q.high_ram_exec_forbid <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[hdl/fpam_core.sv]
// Single-pass access decode: next monitor state and the result of one access.
`default_nettype none

module fpam_core (
  input  wire fpam_pkg::fpam_item_t  item_i,
  input  wire fpam_pkg::fpam_cfg_t   cfg_i,
  input  wire fpam_pkg::fpam_state_t state_i,
  output fpam_pkg::fpam_state_t  state_o,
  output fpam_pkg::fpam_result_t result_o
);

  logic        first_gen, even, is_write, fire;
  logic        in_archive, in_screen, in_toggle, in_low_ram, in_high_ram;
  logic [24:0] rel;
  logic        rel_ok;
  logic        fl_boot, fl_cert, fl_auth_a, fl_prot, fl_auth_b, fl_fetch;
  logic [23:0] fetch_lo;
  logic [1:0]  bit_idx;
  logic [2:0]  bit_mask;
  logic [7:0]  auth1_inc, auth2_inc, tcc_inc, acc_inc, tcc_new, acc_new;
  logic [5:0]  page;
  logic        page_forbid;

  assign first_gen = !cfg_i.hw_generation;
  assign even      = !item_i.address[0];
  assign is_write  = (fpam_pkg::fpam_op_e'(item_i.op) == fpam_pkg::OpWrite);

  assign in_archive  = (item_i.address >= fpam_pkg::ArchiveLo) &&
                       (item_i.address <= fpam_pkg::ArchiveHi);
  assign in_screen   = (item_i.address >= fpam_pkg::ScreenLo) &&
                       (item_i.address <= fpam_pkg::ScreenHi);
  assign in_toggle   = (item_i.address >= fpam_pkg::ToggleLo) &&
                       (item_i.address <= fpam_pkg::ToggleHi);
  assign in_low_ram  = (item_i.address <= fpam_pkg::LowRamHi);
  assign in_high_ram = (item_i.address <= fpam_pkg::HighRamHi);

  // Address relative to the flash base; a set top bit means below the base.
  assign rel    = {1'b0, item_i.address} - {2'b00, cfg_i.rom_page, 16'h0000};
  assign rel_ok = !rel[24];

  assign fl_boot   = rel_ok && (rel[23:0] >= fpam_pkg::FlBootLo) &&
                     (rel[23:0] <= fpam_pkg::FlBootHi);
  assign fl_cert   = rel_ok && (rel[23:0] >= fpam_pkg::FlCertLo) &&
                     (rel[23:0] <= fpam_pkg::FlCertHi);
  assign fl_auth_a = rel_ok && (rel[23:0] >= fpam_pkg::FlAuthALo) &&
                     (rel[23:0] <= fpam_pkg::FlAuthAHi);
  assign fl_prot   = rel_ok && (rel[23:0] >= fpam_pkg::FlProtLo) &&
                     (rel[23:0] <= fpam_pkg::FlProtHi);
  assign fl_auth_b = rel_ok && (rel[23:0] >= fpam_pkg::FlAuthBLo) &&
                     (rel[23:0] <= fpam_pkg::FlAuthBHi);

  assign fetch_lo = fpam_pkg::FlFetchLo + {5'd0, state_i.archive_limit_bits, 16'h0000};
  assign fl_fetch = rel_ok && (rel[23:0] >= fetch_lo) && (rel[23:0] <= fpam_pkg::FlFetchHi);

  assign bit_idx  = item_i.address[19:18] - 2'd1;
  assign bit_mask = 3'b001 << bit_idx;

  assign auth1_inc = fpam_pkg::sat_inc(state_i.auth_count_first);
  assign auth2_inc = fpam_pkg::sat_inc(state_i.auth_count_second);
  assign tcc_inc   = fpam_pkg::sat_inc(state_i.toggle_crash_count);
  assign acc_inc   = fpam_pkg::sat_inc(state_i.archive_crash_count);
  assign tcc_new   = even ? tcc_inc : state_i.toggle_crash_count;
  assign acc_new   = even ? acc_inc : state_i.archive_crash_count;

  assign fire = (state_i.auth_count_first >= fpam_pkg::AuthFireCount) ||
                (auth2_inc == fpam_pkg::AuthSecondFire);

  assign page        = item_i.address[17:12];
  assign page_forbid = ({1'b0, page} < 7'(fpam_pkg::RamPages)) &&
                       cfg_i.ram_exec_forbid_mask[page];

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    case (fpam_pkg::fpam_op_e'(item_i.op))
      fpam_pkg::OpRead, fpam_pkg::OpWrite: begin
        result_o.memory_enable = 1'b1;
        if (in_archive) begin
          if (!state_i.protect_flag && first_gen) begin
            if (is_write) begin
              state_o.archive_limit_bits = state_i.archive_limit_bits | bit_mask;
            end else begin
              state_o.archive_limit_bits = state_i.archive_limit_bits & ~bit_mask;
            end
          end
        end else if (in_screen) begin
          state_o = state_i;
        end else if (in_toggle) begin
          if (fire) begin
            state_o.protect_flag      = !is_write;
            state_o.auth_count_first  = '0;
            state_o.auth_count_second = '0;
          end else begin
            state_o.auth_count_second = auth2_inc;
            if (first_gen) begin
              state_o.toggle_crash_count = tcc_new;
              if (tcc_new >= fpam_pkg::CrashCount) begin
                state_o.auth_count_first   = '0;
                state_o.auth_count_second  = '0;
                state_o.toggle_crash_count = '0;
                result_o.halt_cpu          = 1'b1;
              end
            end
          end
        end else if (fl_boot || fl_auth_a || fl_auth_b) begin
          if (even) begin
            if (first_gen) begin
              state_o.auth_count_first = auth1_inc;
            end else begin
              state_o.auth_count_second = auth2_inc;
            end
          end
          if (fl_boot && is_write) begin
            result_o.memory_enable = 1'b0;
          end
        end else if (fl_cert) begin
          if (!is_write && state_i.protect_flag) begin
            result_o.memory_enable = 1'b0;
            result_o.read_override = 1'b1;
          end
        end else if (fl_prot) begin
          if (is_write) begin
            result_o.memory_enable = 1'b0;
          end else if (state_i.protect_flag) begin
            result_o.memory_enable = 1'b0;
            result_o.read_override = 1'b1;
          end
        end else begin
          state_o.auth_count_first    = '0;
          state_o.auth_count_second   = '0;
          state_o.toggle_crash_count  = '0;
          state_o.archive_crash_count = '0;
        end
        if (is_write) begin
          result_o.read_override = 1'b0;
          if (result_o.memory_enable) begin
            result_o.write_data_out = item_i.write_data;
          end
        end
      end
      fpam_pkg::OpFetch: begin
        if (first_gen) begin
          if (fl_fetch) begin
            state_o.archive_crash_count = acc_new;
            if (acc_new >= fpam_pkg::CrashCount) begin
              state_o.auth_count_first   = '0;
              state_o.auth_count_second  = '0;
              state_o.toggle_crash_count = '0;
              result_o.halt_cpu          = 1'b1;
              result_o.violation         = fpam_pkg::ViolArchive;
            end
          end
        end else if ((in_low_ram && page_forbid) ||
                     (!in_low_ram && in_high_ram && cfg_i.high_ram_exec_forbid)) begin
          state_o.auth_count_first   = '0;
          state_o.auth_count_second  = '0;
          state_o.toggle_crash_count = '0;
          result_o.halt_cpu          = 1'b1;
          result_o.violation         = fpam_pkg::ViolRamExec;
        end
      end
      default: ;
    endcase
    result_o.protect_state     = state_o.protect_flag;
    result_o.archive_limit_now = state_o.archive_limit_bits;
  end

endmodule

`default_nettype wire

[hdl/flash_protection_access_monitor.sv]
// Top level of the flash protection access monitor: input stage, decode, result stage.
//
//   channel   modport  transfer carries
//   item_i    sink     op, address, write_data
//   result_o  source   memory_enable .. archive_limit_now
//   cfg_i     sink     index, data (always ready)
//
// One access per cycle is sustained while result_o.ready is high; an access passes the
// input register, then decode and state update, then the result register.
// Reset clears the protection flag, the archive limit bits and all counters.
// A stalled result holds the result register and, once the input register is
// also full, item_i.ready drops until the result transfer completes.
`default_nettype none

module flash_protection_access_monitor (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fpam_item_if.sink   item_i,
  fpam_result_if.source result_o,
  fpam_cfg_if.sink    cfg_i
);

  fpam_pkg::fpam_item_t   item_q;
  logic                   item_vld_q;
  fpam_pkg::fpam_result_t res_q, res_d;
  logic                   res_vld_q;
  fpam_pkg::fpam_state_t  state_q, state_d;
  fpam_pkg::fpam_cfg_t    cfg;
  logic                   advance;

  fpam_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  fpam_core u_core (
    .item_i   (item_q),
    .cfg_i    (cfg),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign advance      = item_vld_q && (!res_vld_q || result_o.ready);
  assign item_i.ready = !item_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      state_q    <= '0;
    end else begin
      if (item_i.ready) begin
        item_vld_q <= item_i.valid;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
        state_q   <= state_d;
      end else if (result_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q.op         <= item_i.op;
      item_q.address    <= item_i.address;
      item_q.write_data <= item_i.write_data;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid             = res_vld_q;
  assign result_o.memory_enable     = res_q.memory_enable;
  assign result_o.read_override     = res_q.read_override;
  assign result_o.write_data_out    = res_q.write_data_out;
  assign result_o.violation         = res_q.violation;
  assign result_o.halt_cpu          = res_q.halt_cpu;
  assign result_o.protect_state     = res_q.protect_state;
  assign result_o.archive_limit_now = res_q.archive_limit_now;

  a_viol_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (result_o.violation != fpam_pkg::ViolNone) |-> result_o.halt_cpu)
    else $error("violation reported without halting the processor");

  a_override_no_mem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.read_override |-> !result_o.memory_enable)
    else $error("read override with memory still enabled");

  a_wdata_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (result_o.write_data_out != 8'h00) |-> result_o.memory_enable)
    else $error("write data passed on for a dropped access");

  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> result_o.valid && (result_o.protect_state == state_q.protect_flag))
    else $error("decoded access did not reach the result register");

endmodule

`default_nettype wire
